// ===== src/tcw_pkg.sv =====
// Package for the text console writer: beat payload types, controller/datapath
// command and status structs, and shared character and attribute constants.
// No dependencies.
`timescale 1ns / 1ps

package tcw_pkg;

    localparam int ROWS_DEFAULT    = 25;
    localparam int COLUMNS_DEFAULT = 80;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] SPACE_CODE   = 8'd32;
    localparam logic [7:0] ATTR_RESET   = 8'h0A;

    // Register map: one bit of register index, at paddr[2]
    localparam logic REG_ATTRIBUTE = 1'b0;

    typedef enum logic {
        CMD_PUT  = 1'b0,
        CMD_READ = 1'b1
    } t_item_cmd;

    typedef struct packed {
        logic       cmd;
        logic [7:0] char_code;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] cell_char;
        logic [7:0] cell_attr;
        logic [4:0] cursor_row;
        logic [6:0] cursor_col;
    } t_out_beat;

    typedef struct packed {
        logic start;       // item accepted this cycle
        logic clear_step;  // one step of the post-reset clearing sweep
        logic fill_step;   // one step of the scroll fill of the new bottom row
        logic load_out;    // load the result register
    } t_ctrl_cmd;

    typedef struct packed {
        logic clear_last;  // sweep at the last screen entry
        logic fill_last;   // sweep at the last column
        logic scroll;      // last item scrolled the screen
    } t_dp_status;

endpackage

// ===== src/tcw_dpath.sv =====
// Datapath of the text console writer: screen memory (circular row buffer),
// cursor and top-row registers, sweep counter and result register.
// Depends on tcw_pkg.
`timescale 1ns / 1ps

module tcw_dpath #(
    parameter int ROWS    = tcw_pkg::ROWS_DEFAULT,
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tcw_pkg::t_ctrl_cmd    i_cmd,
    output tcw_pkg::t_dp_status   o_status,
    input  tcw_pkg::t_in_beat     i_item,
    input  logic [7:0]            i_attr,
    output tcw_pkg::t_out_beat    o_result
);

    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int AW    = RW + CW;
    localparam int DEPTH = ROWS * (2 ** CW);

    // physical row = (logical row + top) mod ROWS, both operands below ROWS
    function automatic logic [RW-1:0] row_map(input logic [RW-1:0] a,
                                              input logic [RW-1:0] b);
        logic [RW:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= (RW+1)'(ROWS)) begin
            sum = sum - (RW+1)'(ROWS);
        end
        return sum[RW-1:0];
    endfunction

    logic [15:0]   r_mem [DEPTH];
    logic [15:0]   r_rdata;

    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_top, n_top;
    logic [RW-1:0] r_fill_row;
    logic [AW-1:0] r_sweep;
    logic          r_scroll, n_scroll;
    logic          r_show_cell;

    tcw_pkg::t_out_beat r_out;

    logic          is_put, is_newline, wrap;
    logic [CW:0]   col_inc;
    logic [RW-1:0] cur_phys;
    logic [AW-1:0] raddr;
    logic          in_range;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [15:0]   mem_wdata;

    assign is_put     = (i_item.cmd == tcw_pkg::CMD_PUT);
    assign is_newline = (i_item.char_code == tcw_pkg::NEWLINE_CODE);
    assign col_inc    = {1'b0, r_col} + (CW+1)'(1);
    assign wrap       = is_newline || (col_inc >= (CW+1)'(COLUMNS));
    assign cur_phys   = row_map(r_row, r_top);

    assign in_range = ({1'b0, i_item.read_row} < 6'(ROWS))
                   && ({1'b0, i_item.read_col} < 8'(COLUMNS));
    assign raddr    = {row_map(i_item.read_row[RW-1:0], r_top), i_item.read_col[CW-1:0]};

    // cursor advance; a scroll only moves the top pointer
    always_comb begin
        n_row    = r_row;
        n_col    = r_col;
        n_top    = r_top;
        n_scroll = 1'b0;
        if (is_put) begin
            if (wrap) begin
                n_col = '0;
                if (r_row == RW'(ROWS - 1)) begin
                    n_scroll = 1'b1;
                    n_top    = row_map(r_top, RW'(1));
                end else begin
                    n_row = r_row + RW'(1);
                end
            end else begin
                n_col = col_inc[CW-1:0];
            end
        end
    end

    // single write port: item write, clearing sweep or scroll fill
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = {cur_phys, r_col};
        mem_wdata = {i_attr, i_item.char_code};
        if (i_cmd.start) begin
            mem_we = is_put && !is_newline;
        end else if (i_cmd.clear_step) begin
            mem_we    = 1'b1;
            mem_waddr = r_sweep;
            mem_wdata = {tcw_pkg::ATTR_RESET, tcw_pkg::SPACE_CODE};
        end else if (i_cmd.fill_step) begin
            mem_we    = 1'b1;
            mem_waddr = {r_fill_row, r_sweep[CW-1:0]};
            mem_wdata = {i_attr, tcw_pkg::SPACE_CODE};
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.start) begin
            r_rdata <= r_mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row    <= '0;
            r_col    <= '0;
            r_top    <= '0;
            r_sweep  <= '0;
            r_scroll <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_row    <= n_row;
                r_col    <= n_col;
                r_top    <= n_top;
                r_scroll <= n_scroll;
            end
            if (i_cmd.clear_step) begin
                r_sweep <= o_status.clear_last ? '0 : r_sweep + AW'(1);
            end else if (i_cmd.fill_step) begin
                r_sweep <= o_status.fill_last ? '0 : r_sweep + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_fill_row  <= r_top;  // old top becomes the new bottom row
            r_show_cell <= !is_put && in_range;
        end
        if (i_cmd.load_out) begin
            r_out.cell_char  <= r_show_cell ? r_rdata[7:0]  : 8'd0;
            r_out.cell_attr  <= r_show_cell ? r_rdata[15:8] : 8'd0;
            r_out.cursor_row <= 5'(r_row);
            r_out.cursor_col <= 7'(r_col);
        end
    end

    assign o_status.clear_last = (r_sweep == AW'(DEPTH - 1));
    assign o_status.fill_last  = (r_sweep[CW-1:0] == CW'(COLUMNS - 1));
    assign o_status.scroll     = r_scroll;
    assign o_result            = r_out;

`ifndef SYNTH
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_col} < (CW+1)'(COLUMNS)))
        else $error("cursor column off screen");
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_row} < (RW+1)'(ROWS)) && ({1'b0, r_top} < (RW+1)'(ROWS)))
        else $error("cursor or top row off screen");
    a_scroll_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scroll |-> (r_row == RW'(ROWS - 1)) && (r_col == '0))
        else $error("scroll without cursor at start of last row");
`endif

endmodule

// ===== src/tcw_ctrl.sv =====
// Controller of the text console writer: sequences clearing sweep, item
// handling, result hand-off and scroll fill. Depends on tcw_pkg.
`timescale 1ns / 1ps

module tcw_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output tcw_pkg::t_ctrl_cmd    o_cmd,
    input  tcw_pkg::t_dp_status   i_status
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_DONE,
        S_FILL
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_status.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = i_status.scroll ? S_FILL : S_IDLE;
                end
            end
            S_FILL: begin
                o_cmd.fill_step = 1'b1;
                if (i_status.fill_last) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef SYNTH
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || !i_out_stall))
        else $error("result register overwritten while held");
    a_start_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |=> (r_state == S_DONE))
        else $error("accepted item not followed by result stage");
    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_cmd.load_out))
        else $error("result valid without a load");
`endif

endmodule

// ===== src/text_console_writer.sv =====
// Top level of the text console writer: APB attribute register and the
// controller/datapath pair. Depends on tcw_pkg, tcw_ctrl and tcw_dpath.
`timescale 1ns / 1ps

// Text console writer: a ROWS x COLUMNS character screen with a cursor.
// A put beat (cmd 0) writes char_code with the current attribute at the
// cursor and advances it; newline (10) writes nothing and moves to column 0
// of the next row; passing the last row scrolls the screen up one line and
// blanks the bottom line with spaces in the current attribute. A read beat
// (cmd 1) returns one cell (zeros if outside the screen). Every beat gives
// exactly one result beat carrying the cursor after the item.
// Timing: after reset the block clears the screen memory, one entry a
// cycle, over ROWS * 2**clog2(COLUMNS) entries (3200 at 25 x 80) with
// input stalled; configuration writes are taken throughout. An item is
// then accepted; its result is loaded in a separate result state once
// the output register is free, as the screen memory read port is
// registered. Rows live in a circular buffer behind a top-row pointer,
// so a scroll refills only the new bottom row, one cell a cycle through
// the single memory write port. A waiting result does not block the next
// item from being accepted; it only holds the following result.
// Register 0 (byte address 0, bit paddr[2] selects): attribute, 8 bits,
// reset 0x0A; bits 3:0 foreground, 6:4 background, 7 blink.

module text_console_writer #(
    parameter int ROWS    = tcw_pkg::ROWS_DEFAULT,
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // item channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  tcw_pkg::t_in_beat    i_in_data,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output tcw_pkg::t_out_beat   o_out_data,
    // configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    tcw_pkg::t_ctrl_cmd  cmd;
    tcw_pkg::t_dp_status status;

    logic [7:0] r_attr;
    logic       cfg_write;

    // Register write completes on the access phase; pready is tied high.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= tcw_pkg::ATTR_RESET;
        end else if (cfg_write && (paddr[2] == tcw_pkg::REG_ATTRIBUTE)) begin
            r_attr <= pwdata[7:0];
        end
    end

    assign prdata = (paddr[2] == tcw_pkg::REG_ATTRIBUTE) ? {24'd0, r_attr} : 32'd0;

    tcw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    tcw_dpath #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_status (status),
        .i_item   (i_in_data),
        .i_attr   (r_attr),
        .o_result (o_out_data)
    );

endmodule
